[rtl/fwrm_pkg.sv]
// Package for the FIFO with running minimum: sizes, codes, state type,
// memory request structs and the wrap-around and compare helpers.
// No dependencies; fwrm_core and the top level import it.
package fwrm_pkg;

  // Queue geometry.
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SUM_W      = PTR_W + 1;

  // Field widths on the ports.
  localparam int VAL_W      = 32;
  localparam int LEN_W      = 5;
  localparam int ERR_W      = 2;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_DATA_BITS = 2 * VAL_W + LEN_W + 1;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

  // Bit positions in the result tdata.
  localparam int POP_LSB   = 0;
  localparam int MIN_LSB   = VAL_W;
  localparam int LEN_LSB   = 2 * VAL_W;
  localparam int EMPTY_BIT = 2 * VAL_W + LEN_W;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_CAND,
    ST_PUSH_ELEM,
    ST_PUSH_CMP,
    ST_PUSH_WRITE,
    ST_POP_READ,
    ST_POP_CHECK,
    ST_MIN_CAND,
    ST_MIN_ELEM,
    ST_MIN_LOAD,
    ST_FINISH
  } state_t;

  // Request to the element memory.
  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    data_t wdata;
    ptr_t  raddr;
  } elem_req_t;

  // Request to the candidate memory.
  typedef struct packed {
    logic we;
    ptr_t waddr;
    ptr_t wdata;
    ptr_t raddr;
  } cand_req_t;

  // Ring index addition; b is always below CAPACITY.
  function automatic ptr_t wrap_add(ptr_t a, ptr_t b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction

  // Strict less-than, unsigned or two's complement.
  function automatic logic less_than(data_t a, data_t b, logic sgn);
    data_t flip;
    flip = '0;
    flip[DATA_WIDTH-1] = sgn;
    return (a ^ flip) < (b ^ flip);
  endfunction

endpackage

[rtl/fwrm_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module fwrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/fwrm_core.sv]
// Sequencer and datapath of the FIFO with running minimum: ring pointers,
// the shared compare step, the memory requests and the result register.
// Depends on fwrm_pkg; drives the two fwrm_ram instances of the top level.
module fwrm_core
  import fwrm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   signed_cmp,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [ERR_W-1:0]       out_tuser,
  output elem_req_t              elem_req,
  input  data_t                  elem_rdata,
  output cand_req_t              cand_req,
  input  ptr_t                   cand_rdata
);

  state_t state_r, state_nxt;
  data_t  val_r, val_nxt;
  ptr_t   head_r, head_nxt;
  cnt_t   cnt_r, cnt_nxt;
  ptr_t   chead_r, chead_nxt;
  cnt_t   ccnt_r, ccnt_nxt;
  data_t  min_r, min_nxt;
  data_t  popped_r, popped_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [ERR_W-1:0] out_user_r, out_user_nxt;
  ptr_t   slot;
  logic   drop;

  assign slot      = wrap_add(head_r, PTR_W'(cnt_r));
  assign drop      = (ccnt_r != '0) && (cand_rdata == head_r);
  assign in_tready = (state_r == ST_IDLE);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      chead_r     <= '0;
      ccnt_r      <= '0;
      min_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      chead_r     <= chead_nxt;
      ccnt_r      <= ccnt_nxt;
      min_r       <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    popped_r   <= popped_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // Next state, pointer updates and memory requests.
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    chead_nxt     = chead_r;
    ccnt_nxt      = ccnt_r;
    min_nxt       = min_r;
    popped_nxt    = popped_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    elem_req      = '0;
    cand_req      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          val_nxt    = DATA_WIDTH'(in_tdata[VAL_W-1:0]);
          popped_nxt = '0;
          err_nxt    = ERR_NONE;
          if (in_tuser == OP_PUSH) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              err_nxt   = ERR_FULL;
              state_nxt = ST_FINISH;
            end else begin
              state_nxt = ST_PUSH_CAND;
            end
          end else begin
            if (cnt_r == '0) begin
              err_nxt   = ERR_EMPTY;
              state_nxt = ST_FINISH;
            end else begin
              state_nxt = ST_POP_READ;
            end
          end
        end
      end

      // Fetch the slot of the back candidate.
      ST_PUSH_CAND: begin
        if (ccnt_r == '0) begin
          state_nxt = ST_PUSH_WRITE;
        end else begin
          cand_req.raddr = wrap_add(chead_r, PTR_W'(ccnt_r - CNT_W'(1)));
          state_nxt      = ST_PUSH_ELEM;
        end
      end

      // Fetch the value held in that slot.
      ST_PUSH_ELEM: begin
        elem_req.raddr = cand_rdata;
        state_nxt      = ST_PUSH_CMP;
      end

      // Drop the back candidate while it is strictly greater.
      ST_PUSH_CMP: begin
        if (less_than(val_r, elem_rdata, signed_cmp)) begin
          ccnt_nxt  = ccnt_r - CNT_W'(1);
          state_nxt = ST_PUSH_CAND;
        end else begin
          state_nxt = ST_PUSH_WRITE;
        end
      end

      // Append the new slot as a candidate and store the value.
      ST_PUSH_WRITE: begin
        cand_req.we    = 1'b1;
        cand_req.waddr = wrap_add(chead_r, PTR_W'(ccnt_r));
        cand_req.wdata = slot;
        elem_req.we    = 1'b1;
        elem_req.waddr = slot;
        elem_req.wdata = val_r;
        cnt_nxt        = cnt_r + CNT_W'(1);
        ccnt_nxt       = ccnt_r + CNT_W'(1);
        if (ccnt_r == '0) begin
          min_nxt = val_r;
        end
        state_nxt = ST_FINISH;
      end

      // Read the front element and the front candidate together.
      ST_POP_READ: begin
        elem_req.raddr = head_r;
        cand_req.raddr = chead_r;
        state_nxt      = ST_POP_CHECK;
      end

      ST_POP_CHECK: begin
        popped_nxt = elem_rdata;
        head_nxt   = wrap_add(head_r, PTR_W'(1));
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (drop) begin
          chead_nxt = wrap_add(chead_r, PTR_W'(1));
          ccnt_nxt  = ccnt_r - CNT_W'(1);
        end
        state_nxt = ST_FINISH;
        if (cnt_r == CNT_W'(1)) begin
          min_nxt = '0;
        end else if (drop) begin
          if (ccnt_r == CNT_W'(1)) begin
            min_nxt = '0;
          end else begin
            state_nxt = ST_MIN_CAND;
          end
        end
      end

      // Reload the minimum from the new front candidate.
      ST_MIN_CAND: begin
        cand_req.raddr = chead_r;
        state_nxt      = ST_MIN_ELEM;
      end

      ST_MIN_ELEM: begin
        elem_req.raddr = cand_rdata;
        state_nxt      = ST_MIN_LOAD;
      end

      ST_MIN_LOAD: begin
        min_nxt   = elem_rdata;
        state_nxt = ST_FINISH;
      end

      // Hand the result to the output register once it is free.
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {
            {(OUT_TDATA_W - OUT_DATA_BITS){1'b0}},
            (cnt_r == '0),
            LEN_W'(cnt_r),
            VAL_W'(min_r),
            VAL_W'(popped_r)
          };
          out_user_nxt  = err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[rtl/fifo_with_running_minimum_unit.sv]
// FIFO with running minimum, 16 entries of 32 bits, minimum reported per request.
// A push drops back candidates strictly greater than its value, one compare each,
// until a kept one ends the scan or the list empties, then stores the value; a pop
// reloads the minimum when the front candidate leaves; a rejected request goes
// straight to the result. One request at a time: in_tready returns with out_tvalid,
// and a held result stalls the next one.
// Reset (rst_n low, synchronous) empties the queue and clears signed_compare.
module fifo_with_running_minimum_unit
  import fwrm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration channel: signed_compare.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data,
  // Request channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0]
  input  logic                   in_tuser,   // op
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // popped_value, min_value, length, empty_res
  output logic [ERR_W-1:0]       out_tuser   // error
);

  logic      signed_cmp_r;
  elem_req_t elem_req;
  cand_req_t cand_req;
  data_t     elem_rdata;
  ptr_t      cand_rdata;

  // Compare mode register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_cmp_r <= 1'b0;
    end else if (cfg_valid) begin
      signed_cmp_r <= cfg_data;
    end
  end

  // Element ring storage.
  fwrm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_elem_ram (
    .clk   (clk),
    .we    (elem_req.we),
    .waddr (elem_req.waddr),
    .wdata (elem_req.wdata),
    .raddr (elem_req.raddr),
    .rdata (elem_rdata)
  );

  // Candidate slot ring storage.
  fwrm_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_cand_ram (
    .clk   (clk),
    .we    (cand_req.we),
    .waddr (cand_req.waddr),
    .wdata (cand_req.wdata),
    .raddr (cand_req.raddr),
    .rdata (cand_rdata)
  );

  // Sequencer and datapath.
  fwrm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .signed_cmp (signed_cmp_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .elem_req   (elem_req),
    .elem_rdata (elem_rdata),
    .cand_req   (cand_req),
    .cand_rdata (cand_rdata)
  );

  // A request is worked on alone: no new request right after one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in progress");

  // A push rejected for lack of room reports a full queue.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ERR_FULL) |->
      (out_tdata[LEN_LSB +: LEN_W] == LEN_W'(CAPACITY)))
    else $error("push rejected while the queue was not full");

  // A pop on an empty queue reports an empty queue and no value.
  a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ERR_EMPTY) |->
      (out_tdata[EMPTY_BIT] && out_tdata[LEN_LSB +: LEN_W] == '0 &&
       out_tdata[POP_LSB +: VAL_W] == '0))
    else $error("empty pop result is inconsistent");

  // The empty flag and the minimum agree with the length.
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[EMPTY_BIT] == (out_tdata[LEN_LSB +: LEN_W] == '0)) &&
      (!out_tdata[EMPTY_BIT] || out_tdata[MIN_LSB +: VAL_W] == '0)))
    else $error("empty flag or minimum disagrees with the length");

endmodule
